[src/ssdd_pkg.sv]
// ----------------------------------------------------------------------------
// ssdd_pkg
// Shared constants and types for the start/stop delimited deframer.
// ----------------------------------------------------------------------------
package ssdd_pkg;

	localparam int unsigned START_LEN = 4;
	localparam int unsigned STOP_LEN  = 4;

	localparam logic [7:0] START_BYTE      = 8'h55;
	localparam logic [7:0] STOP_BYTE       = 8'hFF;
	localparam logic [7:0] FRAME_LEN_RESET = 8'd16;

	localparam int unsigned WIN_W = START_LEN * 8;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic       frame_ok;
		logic       last_payload;
	} res_t;

endpackage

[src/ssdd_core.sv]
// ----------------------------------------------------------------------------
// ssdd_core
// Frame state machine: start hunt over a sliding window, payload count,
// stop sequence check. Produces at most one result per byte stepped in.
// ----------------------------------------------------------------------------
module ssdd_core
	import ssdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic [7:0] frame_len,
	output logic       res_valid,
	output res_t       res
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_STOP    = 2'd2
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [WIN_W-1:0]   window_q, window_d;
	logic [7:0]         byte_count_q, byte_count_d;
	logic               stop_mismatch_q, stop_mismatch_d;

	logic [8:0]         count_inc;
	logic [WIN_W-1:0]   window_sh;
	logic               start_hit;
	logic               bad_stop;

	assign count_inc = {1'b0, byte_count_q} + 9'd1;
	assign window_sh = {window_q[WIN_W-9:0], rx_byte};
	assign bad_stop  = stop_mismatch_q | (rx_byte != STOP_BYTE);

	// A cleared window holds zeros, so an all-start match implies START_LEN
	// bytes have been shifted in since the clear.
	always_comb begin
		start_hit = 1'b1;
		for (int i = 0; i < int'(START_LEN); i++) begin
			if (window_sh[i*8 +: 8] != START_BYTE) begin
				start_hit = 1'b0;
			end
		end
	end

	always_comb begin
		phase_d         = phase_q;
		window_d        = window_q;
		byte_count_d    = byte_count_q;
		stop_mismatch_d = stop_mismatch_q;
		res_valid       = 1'b0;
		res             = '0;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid    = 1'b1;
				res.out_byte = rx_byte;
				if (count_inc >= {1'b0, frame_len}) begin
					res.last_payload = 1'b1;
					phase_d          = PH_STOP;
					byte_count_d     = '0;
					stop_mismatch_d  = 1'b0;
				end else begin
					byte_count_d = count_inc[7:0];
				end
			end
			PH_STOP: begin
				if (count_inc >= 9'(STOP_LEN)) begin
					res_valid       = 1'b1;
					res.is_status   = 1'b1;
					res.frame_ok    = ~bad_stop;
					phase_d         = PH_HUNT;
					window_d        = '0;
					byte_count_d    = '0;
					stop_mismatch_d = 1'b0;
				end else begin
					byte_count_d    = count_inc[7:0];
					stop_mismatch_d = bad_stop;
				end
			end
			default: begin
				// hunting, and the unused code behaves the same
				phase_d  = PH_HUNT;
				window_d = window_sh;
				if (start_hit) begin
					byte_count_d    = '0;
					stop_mismatch_d = 1'b0;
					phase_d         = (frame_len == 8'd0) ? PH_STOP : PH_PAYLOAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			window_q        <= '0;
			byte_count_q    <= '0;
			stop_mismatch_q <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			window_q        <= window_d;
			byte_count_q    <= byte_count_d;
			stop_mismatch_q <= stop_mismatch_d;
		end
	end

endmodule

[src/ssdd_out_reg.sv]
// ----------------------------------------------------------------------------
// ssdd_out_reg
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
module ssdd_out_reg
	import ssdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       res_valid,
	input  res_t       res,
	output logic       space,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic       frame_ok,
	output logic       last_payload
);

	logic valid_q;
	res_t res_q;

	// free when empty or the held beat leaves this cycle
	assign space = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = res_q.out_byte;
	assign is_status    = res_q.is_status;
	assign frame_ok     = res_q.frame_ok;
	assign last_payload = res_q.last_payload;

endmodule

[src/start_stop_delimited_deframer.sv]
// An accepted byte is held in the input register until the output register has
// space; it is then processed and its result, if any, is loaded into the output register.
// Throughput: one byte per cycle while the output register has space; the frame state updates once per byte.
// Reset (arst_n low): block hunts for a start with a cleared window, no
// result is pending, and the frame length register returns to 16.
// ----------------------------------------------------------------------------
// start_stop_delimited_deframer
// Finds a 0x55 start sequence, passes on the configured number of bytes,
// then checks the 0xFF stop sequence and reports frame status.
// ----------------------------------------------------------------------------
module start_stop_delimited_deframer
	import ssdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic       frame_ok,
	output logic       last_payload
);

	logic [7:0] frame_len_q;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       space;
	logic       advance;
	logic       res_valid;
	res_t       res;

	assign advance  = valid_s1 & space;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FRAME_LEN_RESET;
		end else if (cfg_we) begin
			frame_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ssdd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (rx_byte_s1),
		.frame_len   (frame_len_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	ssdd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.res_valid    (res_valid),
		.res          (res),
		.space        (space),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_status    (is_status),
		.frame_ok     (frame_ok),
		.last_payload (last_payload)
	);

endmodule

[sim/tb_start_stop_delimited_deframer.sv]
// ----------------------------------------------------------------------------
// tb_start_stop_delimited_deframer
// Streams bytes into the deframer with random gaps and back-pressure and
// tracks the framing state alongside it. Every payload and status beat that
// comes out is checked field by field against the tracked frame state.
// ----------------------------------------------------------------------------
module tb_start_stop_delimited_deframer;
	import ssdd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;

	typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_STOP} frame_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       is_status;
	logic       frame_ok;
	logic       last_payload;

	start_stop_delimited_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_status    (is_status),
		.frame_ok     (frame_ok),
		.last_payload (last_payload)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tracked frame state
	logic [7:0]       fr_len = FRAME_LEN_RESET;
	frame_phase_t     fr_phase = PH_HUNT;
	logic [WIN_W-1:0] fr_window = '0;
	int               fr_fill = 0;
	logic [7:0]       fr_count = 8'd0;
	logic             fr_bad = 1'b0;

	logic [7:0] byte_queue[$];
	res_t       expected_beats[$];

	int  bytes_queued = 0;
	int  bytes_sent = 0;
	int  payload_seen = 0;
	int  status_seen = 0;
	int  bad_frames = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  tx_gap = 0;
	int  tx_burst = 0;
	int  rx_gap = 0;
	int  rx_burst = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	logic in_taken = 1'b0;

	task automatic deframe_byte(input logic [7:0] b);
		res_t r;
		logic fin;
		r = '0;
		case (fr_phase)
			PH_PAYLOAD: begin
				fin = (int'(fr_count) + 1) >= int'(fr_len);
				r.out_byte = b;
				r.last_payload = fin;
				expected_beats.push_back(r);
				if (fin) begin
					fr_phase = PH_STOP;
					fr_count = 8'd0;
					fr_bad = 1'b0;
				end else begin
					fr_count = fr_count + 8'd1;
				end
			end
			PH_STOP: begin
				if (b != STOP_BYTE)
					fr_bad = 1'b1;
				fr_count = fr_count + 8'd1;
				if (fr_count >= STOP_LEN) begin
					r.is_status = 1'b1;
					r.frame_ok = !fr_bad;
					expected_beats.push_back(r);
					fr_phase = PH_HUNT;
					fr_window = '0;
					fr_fill = 0;
					fr_count = 8'd0;
					fr_bad = 1'b0;
				end
			end
			default: begin
				fr_phase = PH_HUNT;
				fr_window = {fr_window[WIN_W-9:0], b};
				if (fr_fill < int'(START_LEN))
					fr_fill++;
				if (fr_fill >= int'(START_LEN) && fr_window == {START_LEN{START_BYTE}}) begin
					fr_count = 8'd0;
					fr_bad = 1'b0;
					fr_phase = (fr_len == 8'd0) ? PH_STOP : PH_PAYLOAD;
				end
			end
		endcase
	endtask

	// sender: acceptance side
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				bytes_sent++;
			end
		end
	end

	// sender: drive side
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (byte_queue.size() != 0) begin
				rx_byte <= byte_queue.pop_front();
				in_valid <= 1'b1;
				if (tx_burst > 0) begin
					tx_burst--;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:2]:   tx_burst = $urandom_range(20, 80);
						[3:54]:  tx_gap = 0;
						[55:91]: tx_gap = $urandom_range(1, 3);
						default: tx_gap = $urandom_range(8, 40);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: ready with random stalls, plus one long hold on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ready <= 1'b1;
				if (rx_burst > 0) begin
					rx_burst--;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:1]:   rx_burst = $urandom_range(30, 100);
						[2:59]:  rx_gap = 0;
						[60:91]: rx_gap = $urandom_range(1, 3);
						default: rx_gap = $urandom_range(10, 40);
					endcase
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat out_byte %02h is_status %0b frame_ok %0b last %0b",
					$time, out_byte, is_status, frame_ok, last_payload);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				check_field("out_byte", want.out_byte, out_byte);
				check_field("is_status", want.is_status, is_status);
				check_field("frame_ok", want.frame_ok, frame_ok);
				check_field("last_payload", want.last_payload, last_payload);
				if (want.is_status) begin
					status_seen++;
					if (!want.frame_ok)
						bad_frames++;
				end else begin
					payload_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
			$display("start_stop_delimited_deframer test failed");
			$finish;
		end
	end

	task automatic put(input logic [7:0] b);
		byte_queue.push_back(b);
		bytes_queued++;
	endtask

	task automatic put_rep(input logic [7:0] b, input int n);
		repeat (n) put(b);
	endtask

	// waits until all bytes are in, all beats are out, and the block has settled
	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_len(input logic [7:0] v);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		fr_len = v;
	endtask

	// noise, then start, payload and stop with random content
	task automatic queue_frame(input int plen);
		logic [7:0] x;
		int n;
		case ($urandom_range(0, 99)) inside
			[0:14]: begin
				// broken start sequence
				put_rep(START_BYTE, $urandom_range(1, 3));
				do x = 8'($urandom_range(0, 255)); while (x == START_BYTE);
				put(x);
			end
			[15:59]: begin
				n = $urandom_range(1, 3);
				repeat (n) put(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		put_rep(START_BYTE, START_LEN);
		repeat (plen) begin
			case ($urandom_range(0, 9))
				0:       put(8'h00);
				1:       put(8'hFF);
				2:       put(START_BYTE);
				default: put(8'($urandom_range(0, 255)));
			endcase
		end
		if ($urandom_range(0, 99) < 80) begin
			put_rep(STOP_BYTE, STOP_LEN);
		end else begin
			repeat (STOP_LEN)
				put(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : STOP_BYTE);
		end
	endtask

	initial begin
		logic [7:0] plan[$];
		int mark;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty payload: noise, start, stop with a bad first byte
		write_frame_len(8'd0);
		put(8'hAA);
		put_rep(START_BYTE, START_LEN);
		put(START_BYTE);
		put_rep(STOP_BYTE, STOP_LEN - 1);
		wait_idle();

		// length dropped below the count already passed mid-frame
		write_frame_len(8'd3);
		put_rep(START_BYTE, START_LEN);
		put(8'h00);
		put(8'hFF);
		wait_idle();
		write_frame_len(8'd1);
		put(START_BYTE);
		put_rep(STOP_BYTE, STOP_LEN);
		wait_idle();

		plan = '{8'd16, 8'd3, 8'd1, 8'd255, 8'd0, 8'd7, 8'd2,
			8'($urandom_range(4, 31)), 8'($urandom_range(0, 12)), 8'd5};
		foreach (plan[i]) begin
			write_frame_len(plan[i]);
			mark = bytes_queued;
			if (plan[i] == 8'd255) begin
				// one full-size frame while the receiver stalls, to back up the input
				queue_frame(255);
				@(posedge clk);
				hold_req = 1'b1;
			end else begin
				while (bytes_queued - mark < 56)
					queue_frame(int'(plan[i]));
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d bytes; checked %0d payload beats and %0d status beats (%0d bad stops),",
			bytes_sent, payload_seen, status_seen, bad_frames);
		$display("over payload lengths 0 to 255 with a long output stall and mid-frame length change.");
		if (mismatches == 0) begin
			$display("start_stop_delimited_deframer test passed");
		end else begin
			$display("start_stop_delimited_deframer test failed");
		end
		$finish;
	end

endmodule
